// ===== hw/rtl/ufd_pkg.sv =====
package ufd_pkg;

   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned LengthWidth  = 16;
   localparam int unsigned KindWidth    = 2;
   localparam int unsigned CsrAddrWidth = 1;
   localparam int unsigned CsrDataWidth = 16;
   localparam int unsigned RspDataWidth = 48;

   localparam logic [ByteWidth-1:0]   StartByteReset = 8'h02;
   localparam logic [LengthWidth-1:0] MaxLengthReset = 16'd255;

   // register indexes on the csr port
   localparam logic [CsrAddrWidth-1:0] CSR_START_BYTE = 1'b0;
   localparam logic [CsrAddrWidth-1:0] CSR_MAX_LENGTH = 1'b1;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_CMD     = 3'd1,
      PH_LEN_LO  = 3'd2,
      PH_LEN_HI  = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CHECK   = 3'd5
   } phase_type;

   typedef enum logic [KindWidth-1:0] {
      KIND_DATA   = 2'd0,
      KIND_GOOD   = 2'd1,
      KIND_BAD    = 2'd2,
      KIND_REJECT = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [ByteWidth-1:0]   command;
      logic [LengthWidth-1:0] frame_length;
      logic [ByteWidth-1:0]   data_byte;
      logic [LengthWidth-1:0] position;
      logic                   last;
   } rsp_type;

endpackage

// ===== hw/rtl/ufd_in_reg.sv =====
module ufd_in_reg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [ufd_pkg::ByteWidth-1:0] req_tdata,
   input  logic                          advance,
   output logic                          byte_valid,
   output logic [ufd_pkg::ByteWidth-1:0] byte_data
);
   import ufd_pkg::*;

   logic                 valid_ff;
   logic                 valid_in;
   logic [ByteWidth-1:0] data_ff;
   logic                 take;

   // the slot frees in the same cycle its byte moves on
   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= req_tdata;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

endmodule

// ===== hw/rtl/ufd_parse.sv =====
module ufd_parse (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic [ufd_pkg::ByteWidth-1:0]   rx_byte,
   input  logic [ufd_pkg::ByteWidth-1:0]   start_byte,
   input  logic [ufd_pkg::LengthWidth-1:0] max_length,
   output logic                            res_valid,
   output ufd_pkg::rsp_type                res
);
   import ufd_pkg::*;

   phase_type              phase_ff;
   phase_type              phase_in;
   logic [ByteWidth-1:0]   command_ff;
   logic [ByteWidth-1:0]   command_in;
   logic [LengthWidth-1:0] length_ff;
   logic [LengthWidth-1:0] length_in;
   logic [LengthWidth-1:0] count_ff;
   logic [LengthWidth-1:0] count_in;
   logic [ByteWidth-1:0]   xor_ff;
   logic [ByteWidth-1:0]   xor_in;
   logic [LengthWidth:0]   count_next;
   logic                   fin;
   logic                   too_long;

   assign count_next = {1'b0, count_ff} + {{LengthWidth{1'b0}}, 1'b1};
   assign fin        = count_next >= {1'b0, length_ff};
   // full length as it stands once the high byte is in
   assign too_long   = {rx_byte, length_ff[ByteWidth-1:0]} > max_length;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_HUNT:    if (rx_byte == start_byte) phase_in = PH_CMD;
         PH_CMD:     phase_in = PH_LEN_LO;
         PH_LEN_LO:  phase_in = PH_LEN_HI;
         PH_LEN_HI: begin
            if (too_long) begin
               phase_in = PH_HUNT;
            end else if ({rx_byte, length_ff[ByteWidth-1:0]} == '0) begin
               phase_in = PH_CHECK;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: if (fin) phase_in = PH_CHECK;
         PH_CHECK:   phase_in = PH_HUNT;
         default:    phase_in = PH_HUNT;
      endcase
   end

   // held fields and result
   always_comb begin
      command_in       = command_ff;
      length_in        = length_ff;
      count_in         = count_ff;
      xor_in           = xor_ff;
      res_valid        = 1'b0;
      res.kind         = KIND_DATA;
      res.data_byte    = '0;
      res.position     = '0;
      res.last         = 1'b0;
      case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == start_byte) xor_in = rx_byte;
         end
         PH_CMD: begin
            command_in = rx_byte;
            xor_in     = xor_ff ^ rx_byte;
         end
         PH_LEN_LO: begin
            length_in = {{(LengthWidth-ByteWidth){1'b0}}, rx_byte};
            xor_in    = xor_ff ^ rx_byte;
         end
         PH_LEN_HI: begin
            length_in = {rx_byte, length_ff[ByteWidth-1:0]};
            xor_in    = xor_ff ^ rx_byte;
            count_in  = '0;
            if (too_long) begin
               res_valid = 1'b1;
               res.kind  = KIND_REJECT;
            end
         end
         PH_PAYLOAD: begin
            xor_in        = xor_ff ^ rx_byte;
            count_in      = count_next[LengthWidth-1:0];
            res_valid     = 1'b1;
            res.kind      = KIND_DATA;
            res.data_byte = rx_byte;
            res.position  = count_ff;
            res.last      = fin;
         end
         PH_CHECK: begin
            res_valid = 1'b1;
            res.kind  = (rx_byte == xor_ff) ? KIND_GOOD : KIND_BAD;
         end
         default: begin
         end
      endcase
      res.command      = command_in;
      res.frame_length = length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         command_ff <= '0;
         length_ff  <= '0;
         count_ff   <= '0;
         xor_ff     <= '0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         command_ff <= command_in;
         length_ff  <= length_in;
         count_ff   <= count_in;
         xor_ff     <= xor_in;
      end
   end

endmodule

// ===== hw/rtl/ufd_out_reg.sv =====
module ufd_out_reg (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  ufd_pkg::rsp_type                 res,
   output logic                             free,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ufd_pkg::RspDataWidth-1:0] rsp_tdata,
   output logic [ufd_pkg::KindWidth-1:0]    rsp_tuser,
   output logic                             rsp_tlast
);
   import ufd_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type res_ff;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {res_ff.position, res_ff.data_byte, res_ff.frame_length, res_ff.command};
   assign rsp_tuser  = res_ff.kind;
   assign rsp_tlast  = res_ff.last;

endmodule

// ===== hw/rtl/uart_frame_deframer_xor.sv =====
// A request passes the input register, then the result register.
// Throughput: one request per cycle while the result side does not stall;
// the input register and the result register both move in the same cycle,
// so a full pipe keeps streaming. Header and hunted-over bytes give no
// result, but for a high length byte over the limit, which gives a reject.
// Reset (synchronous, active high): both stages empty, parser hunting for
// the start byte, start_byte = 0x02, max_length = 255.
module uart_frame_deframer_xor (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ufd_pkg::ByteWidth-1:0]    req_tdata,  // [7:0] rx_byte
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [7:0] command, [23:8] frame_length, [31:24] data_byte, [47:32] position
   output logic [ufd_pkg::RspDataWidth-1:0] rsp_tdata,
   output logic [ufd_pkg::KindWidth-1:0]    rsp_tuser,  // [1:0] kind
   output logic                             rsp_tlast,  // last payload byte
   // register write port
   input  logic                             csr_we,
   input  logic [ufd_pkg::CsrAddrWidth-1:0] csr_addr,
   input  logic [ufd_pkg::CsrDataWidth-1:0] csr_wdata
);
   import ufd_pkg::*;

   logic [ByteWidth-1:0]   start_byte_ff;
   logic [LengthWidth-1:0] max_length_ff;
   logic                   byte_valid;
   logic [ByteWidth-1:0]   byte_data;
   logic                   out_free;
   logic                   advance;
   logic                   res_valid;
   rsp_type                res;

   // Configuration registers; the user must write them only while the block is idle; the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= StartByteReset;
         max_length_ff <= MaxLengthReset;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_START_BYTE: start_byte_ff <= csr_wdata[ByteWidth-1:0];
            CSR_MAX_LENGTH: max_length_ff <= csr_wdata[LengthWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   // Advance the held byte whenever the result register can take whatever
   // it yields; a byte with no result waits too while the result side is
   // full, since holding it as well keeps the control a single term.
   assign advance = byte_valid && out_free;

   ufd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   // Frame state machine: header, payload pass-through, checksum verdict.
   ufd_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .rx_byte    (byte_data),
      .start_byte (start_byte_ff),
      .max_length (max_length_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   ufd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && res_valid),
      .res        (res),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

// Bench for the UART frame deframer. A byte stream is pushed through the
// request channel. A predictor tracks the parser state and the running XOR of
// each frame and queues the result every request should cause. Each accepted
// result is compared field by field with the oldest queued one. Both sides
// stall in random bursts, and the registers are rewritten between phases.
module testbench;
   import ufd_pkg::*;

   localparam int RandomItems = 1400;
   localparam int LimitCycles = 600000;
   localparam int PrintCap    = 40;

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ByteWidth-1:0]    req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic [KindWidth-1:0]    rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_we     = 1'b0;
   logic [CsrAddrWidth-1:0] csr_addr   = '0;
   logic [CsrDataWidth-1:0] csr_wdata  = '0;

   uart_frame_deframer_xor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Register mirror, as the block holds it after reset.
   logic [ByteWidth-1:0]   cfg_start = StartByteReset;
   logic [LengthWidth-1:0] cfg_max   = MaxLengthReset;

   // Parser mirror: where the frame stands and what it has gathered so far.
   phase_type              frame_phase = PH_HUNT;
   logic [ByteWidth-1:0]   hdr_command = '0;
   logic [LengthWidth-1:0] hdr_length  = '0;
   logic [LengthWidth-1:0] frame_count = '0;
   logic [ByteWidth-1:0]   frame_xor   = '0;

   rsp_type pending_rsp[$];

   bit gaps_on   = 1'b0;
   bit stalls_on = 1'b0;
   int stall_left;
   int cycle_count;
   int error_count;
   int rsp_count;
   int items_used;
   int settings_used = 1;
   int kind_seen[4];

   // Build one expected result from the frame currently held.
   function automatic rsp_type make_rsp(kind_type k, logic [7:0] data, logic [15:0] pos,
                                        logic fin);
      rsp_type r;
      r.kind         = k;
      r.command      = hdr_command;
      r.frame_length = hdr_length;
      r.data_byte    = data;
      r.position     = pos;
      r.last         = fin;
      return r;
   endfunction

   // Advance the parser mirror by one received byte; queue the result it causes.
   task automatic deframe_byte(input logic [7:0] rx);
      logic [16:0] next_count;
      logic        fin;
      items_used++;
      case (frame_phase)
         PH_HUNT: begin
            if (rx == cfg_start) begin
               frame_xor   = rx;
               frame_phase = PH_CMD;
            end
         end
         PH_CMD: begin
            hdr_command = rx;
            frame_xor   = frame_xor ^ rx;
            frame_phase = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            hdr_length  = {8'h00, rx};
            frame_xor   = frame_xor ^ rx;
            frame_phase = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            // Length limit is sampled here, on the high byte.
            hdr_length[15:8] = rx;
            frame_xor        = frame_xor ^ rx;
            frame_count      = '0;
            if (hdr_length > cfg_max) begin
               pending_rsp.push_back(make_rsp(KIND_REJECT, '0, '0, 1'b0));
               frame_phase = PH_HUNT;
            end else begin
               frame_phase = (hdr_length == 0) ? PH_CHECK : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            next_count = {1'b0, frame_count} + 17'd1;
            fin        = (next_count >= {1'b0, hdr_length});
            frame_xor  = frame_xor ^ rx;
            pending_rsp.push_back(make_rsp(KIND_DATA, rx, frame_count, fin));
            frame_count = next_count[15:0];
            if (fin) frame_phase = PH_CHECK;
         end
         PH_CHECK: begin
            pending_rsp.push_back(make_rsp((rx == frame_xor) ? KIND_GOOD : KIND_BAD,
                                           '0, '0, 1'b0));
            frame_phase = PH_HUNT;
         end
         default: begin
            frame_phase = PH_HUNT;
         end
      endcase
   endtask

   // Offer one request, with an optional random gap first; return once accepted.
   task automatic send_byte(input logic [7:0] rx);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      do @(posedge clock); while (!req_tready);
      deframe_byte(rx);
   endtask

   // Hold requests until every queued result is out, then let the pipe settle.
   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      // Header bytes leave no result behind; give them time to pass through.
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrAddrWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == CSR_START_BYTE) cfg_start = value[7:0];
      else if (idx == CSR_MAX_LENGTH) cfg_max = value;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Send a complete frame with random payload; stop after the header when the
   // length is over the limit, since the parser returns to hunting there.
   task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len,
                             input bit corrupt);
      logic [7:0] sum;
      logic [7:0] data;
      sum = cfg_start ^ cmd ^ len[7:0] ^ len[15:8];
      send_byte(cfg_start);
      send_byte(cmd);
      send_byte(len[7:0]);
      send_byte(len[15:8]);
      if (len <= cfg_max) begin
         for (int i = 0; i < int'(len); i++) begin
            // Mix in the start value now and then: inside a frame it is plain data.
            data = ($urandom_range(0, 7) == 0) ? cfg_start : 8'($urandom);
            sum  = sum ^ data;
            send_byte(data);
         end
         send_byte(corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      error_count++;
      if (error_count <= PrintCap)
         $display("ERROR result %0d at %0t: %s is 0x%0h, predicted 0x%0h",
                  rsp_count, $realtime, what, got, want);
   endtask

   // Result sink: stall in random bursts while stalls are enabled.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 13) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare every accepted result with the oldest prediction.
   always @(posedge clock) begin : check_rsp
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind         = kind_type'(rsp_tuser);
         got.command      = rsp_tdata[7:0];
         got.frame_length = rsp_tdata[23:8];
         got.data_byte    = rsp_tdata[31:24];
         got.position     = rsp_tdata[47:32];
         got.last         = rsp_tlast;
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected result, kind", 16'(got.kind), '0);
         end else begin
            want = pending_rsp.pop_front();
            kind_seen[want.kind]++;
            if (got.kind !== want.kind)
               report_mismatch("kind", 16'(got.kind), 16'(want.kind));
            if (got.command !== want.command)
               report_mismatch("command", 16'(got.command), 16'(want.command));
            if (got.frame_length !== want.frame_length)
               report_mismatch("frame_length", got.frame_length, want.frame_length);
            if (got.data_byte !== want.data_byte)
               report_mismatch("data_byte", 16'(got.data_byte), 16'(want.data_byte));
            if (got.position !== want.position)
               report_mismatch("position", got.position, want.position);
            if (got.last !== want.last)
               report_mismatch("last", 16'(got.last), 16'(want.last));
         end
         rsp_count++;
      end
   end

   // Watchdog: a hang or a lost result ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LimitCycles) begin
         $display("ERROR timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_rsp.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // Reset settings: noise, extreme bytes, zero length, bad checksum, oversize.
   task automatic test_directed_frames();
      // Noise while hunting: drop both.
      send_byte(8'h00);
      send_byte(8'hFF);
      // Two-byte payload, the first byte equal to the start value.
      send_byte(8'h02); send_byte(8'hFF); send_byte(8'h02); send_byte(8'h00);
      send_byte(8'h02); send_byte(8'hFF); send_byte(8'h02);
      // Zero length: straight to the checksum.
      send_byte(8'h02); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
      send_byte(8'h02);
      // Checksum off by everything.
      send_byte(8'h02); send_byte(8'h5A); send_byte(8'h01); send_byte(8'h00);
      send_byte(8'h00); send_byte(8'hA6);
      // Largest possible length, far over the limit.
      send_byte(8'h02); send_byte(8'h11); send_byte(8'hFF); send_byte(8'hFF);
   endtask

   // Register changes between frames and while a header is half read.
   task automatic test_mid_frame_writes();
      wait_for_quiet();
      write_reg(CSR_START_BYTE, 16'h00FF);
      write_reg(CSR_MAX_LENGTH, 16'h0000);
      settings_used++;
      // Zero length is still allowed with a limit of zero.
      send_byte(8'hFF); send_byte(8'h7E); send_byte(8'h00); send_byte(8'h00);
      send_byte(8'h81);
      // Raise the limit between the length bytes; the high byte samples it.
      send_byte(8'hFF); send_byte(8'h01); send_byte(8'h01);
      wait_for_quiet();
      write_reg(CSR_MAX_LENGTH, 16'h0001);
      send_byte(8'h00); send_byte(8'hFF); send_byte(8'h00);
      // Swap the start value after the command byte; the open frame goes on.
      send_byte(8'hFF); send_byte(8'h22);
      wait_for_quiet();
      write_reg(CSR_START_BYTE, 16'(StartByteReset));
      settings_used++;
      send_byte(8'h00); send_byte(8'h00); send_byte(8'hDD);
      // Old start value is noise now.
      send_byte(8'hFF);
   endtask

   // One long payload, so the position field reaches past its low byte.
   task automatic test_long_frame();
      wait_for_quiet();
      write_reg(CSR_MAX_LENGTH, 16'hFFFE);
      settings_used++;
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      send_frame(8'($urandom), 16'd300, 1'b0);
      send_frame(8'($urandom), 16'hFFFF, 1'b0);
   endtask

   // Mostly well-formed frames with random content, some noise and cut frames.
   task automatic test_random_traffic();
      int         next_setting;
      int         pick;
      bit         quiet_tail;
      logic [15:0] len;
      logic [7:0]  noise;
      next_setting = 0;
      quiet_tail   = 1'b0;
      items_used   = 0;
      while (items_used < RandomItems) begin
         if (!quiet_tail && items_used >= RandomItems * 9 / 10) begin
            gaps_on    = 1'b0;
            stalls_on  = 1'b0;
            quiet_tail = 1'b1;
         end
         if (!quiet_tail && items_used >= next_setting) begin
            // Reprogram between phases only, with every result delivered.
            wait_for_quiet();
            case ($urandom_range(0, 5))
               0:       write_reg(CSR_START_BYTE, 16'h0000);
               1:       write_reg(CSR_START_BYTE, 16'h00FF);
               2:       write_reg(CSR_START_BYTE, 16'(StartByteReset));
               default: write_reg(CSR_START_BYTE, 16'($urandom_range(0, 255)));
            endcase
            case ($urandom_range(0, 6))
               0:       write_reg(CSR_MAX_LENGTH, 16'h0000);
               1:       write_reg(CSR_MAX_LENGTH, 16'hFFFF);
               2:       write_reg(CSR_MAX_LENGTH, MaxLengthReset);
               3:       write_reg(CSR_MAX_LENGTH, 16'h0001);
               4, 5:    write_reg(CSR_MAX_LENGTH, 16'($urandom_range(0, 20)));
               default: write_reg(CSR_MAX_LENGTH, 16'($urandom));
            endcase
            settings_used++;
            gaps_on      = ($urandom_range(0, 3) != 0);
            stalls_on    = ($urandom_range(0, 3) != 0);
            next_setting = items_used + $urandom_range(120, 260);
         end
         pick = $urandom_range(0, 19);
         if (pick < 2) begin
            // Line noise, kept off the start value.
            repeat ($urandom_range(1, 4)) begin
               noise = 8'($urandom);
               if (noise == cfg_start) noise = noise ^ 8'h01;
               send_byte(noise);
            end
         end else if (pick == 2) begin
            // Cut header: whatever follows gets parsed as the rest of it.
            send_byte(cfg_start);
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
         end else begin
            pick = $urandom_range(0, 9);
            if (pick == 0 && cfg_max != 16'hFFFF)
               len = $urandom_range(0, 1) ? cfg_max + 16'd1
                                          : 16'($urandom_range(int'(cfg_max) + 1, 65535));
            else if (pick == 1 && cfg_max <= 40)
               len = cfg_max;
            else
               len = 16'($urandom_range(0, (cfg_max < 12) ? int'(cfg_max) : 12));
            send_frame(8'($urandom), len, $urandom_range(0, 4) == 0);
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_mid_frame_writes();
      test_long_frame();
      test_random_traffic();
      // Drain: every prediction must be met, then watch for strays.
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Covered %0d results over %0d register settings in %0d cycles:",
               rsp_count, settings_used, cycle_count);
      $display("  %0d payload bytes, %0d good, %0d bad checksum, %0d length rejects",
               kind_seen[KIND_DATA], kind_seen[KIND_GOOD], kind_seen[KIND_BAD],
               kind_seen[KIND_REJECT]);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
